[rtl/irfb_pkg.sv]
// Shared types, frame constants and CRC-8 helpers for the IMU record frame builder.
// No dependencies; every other file in rtl/ imports this package.
package irfb_pkg;

    // One IMU record as it arrives on the input channel.
    typedef struct packed {
        logic [63:0]        timestamp_ms;
        logic [63:0]        accel_xy;
        logic [31:0]        accel_z;
        logic [63:0]        rate_xy;
        logic [31:0]        rate_z;
        logic [63:0]        att_yaw_pitch;
        logic [31:0]        att_roll;
        logic [63:0]        quat_01;
        logic [63:0]        quat_23;
        logic signed [15:0] temperature_tenths;
        logic [15:0]        status;
    } imu_record_t;

    // One output beat: four frame bytes, earliest wire byte in bits 7:0.
    typedef struct packed {
        logic [31:0] out_word;
        logic        last_word;
    } frame_word_t;

    // Frame geometry.
    localparam int BODY_WORDS  = 17;
    localparam int BODY_BYTES  = 4 * BODY_WORDS;
    localparam int WORD_IDX_W  = 5;
    localparam logic [WORD_IDX_W-1:0] FIRST_WORD_IDX = 5'd0;
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX  = 5'd17;

    // A frame ready for the serializer: bytes 0..67 as words, plus byte 68.
    typedef struct packed {
        logic [BODY_WORDS-1:0][31:0] words;
        logic [7:0]                  status_byte;
    } frame_body_t;

    // Fixed frame bytes.
    localparam logic [7:0] HDR_SYNC0  = 8'hA5;
    localparam logic [7:0] HDR_SYNC1  = 8'h5A;
    localparam logic [7:0] HDR_ZERO   = 8'h00;
    localparam logic [7:0] CMD_CLASS  = 8'h10;
    localparam logic [7:0] CMD_ID     = 8'h40;
    localparam logic [7:0] FOOTER_CR  = 8'h0D;
    localparam logic [7:0] FOOTER_LF  = 8'h0A;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    // First word of every frame, used by the checker.
    localparam logic [31:0] HDR_WORD = {CMD_CLASS, HDR_ZERO, HDR_SYNC1, HDR_SYNC0};

    // CRC-8, poly 0x07, MSB first, one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC-8 over four bytes of a word, low byte first; a flat XOR network.
    function automatic logic [7:0] crc8_word(input logic [7:0] crc_in, input logic [31:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 0; i < 4; i++) begin
            c = crc8_byte(c, data[8*i +: 8]);
        end
        return c;
    endfunction

endpackage

[rtl/irfb_front.sv]
// Front end: accepts IMU records, advances the frame counter and lays out frame bytes 0..68.
// Depends on irfb_pkg.
module irfb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  irfb_pkg::imu_record_t in_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output irfb_pkg::frame_body_t push_data
);
    import irfb_pkg::*;

    logic [7:0]                  count_reg;
    logic [7:0]                  count_next;
    logic [BODY_BYTES-1:0][7:0]  body_bytes;
    logic                        accept;

    // Handshake passes straight through to the queue.
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // The counter is bumped before use, so the first frame carries 1.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Little-endian byte layout; attitude goes out as pitch, roll, yaw.
    always_comb
    begin
        body_bytes[0]      = HDR_SYNC0;
        body_bytes[1]      = HDR_SYNC1;
        body_bytes[2]      = HDR_ZERO;
        body_bytes[3]      = CMD_CLASS;
        body_bytes[4]      = CMD_ID;
        body_bytes[5]      = count_reg + 8'd1;
        body_bytes[13:6]   = in_data.timestamp_ms;
        body_bytes[17:14]  = in_data.accel_xy[31:0];
        body_bytes[21:18]  = in_data.accel_xy[63:32];
        body_bytes[25:22]  = in_data.accel_z;
        body_bytes[29:26]  = in_data.rate_xy[31:0];
        body_bytes[33:30]  = in_data.rate_xy[63:32];
        body_bytes[37:34]  = in_data.rate_z;
        body_bytes[41:38]  = in_data.att_yaw_pitch[63:32];
        body_bytes[45:42]  = in_data.att_roll;
        body_bytes[49:46]  = in_data.att_yaw_pitch[31:0];
        body_bytes[53:50]  = in_data.quat_01[31:0];
        body_bytes[57:54]  = in_data.quat_01[63:32];
        body_bytes[61:58]  = in_data.quat_23[31:0];
        body_bytes[65:62]  = in_data.quat_23[63:32];
        body_bytes[67:66]  = $unsigned(in_data.temperature_tenths);
    end

    assign push_data.words       = body_bytes;
    assign push_data.status_byte = in_data.status[7:0];

endmodule

[rtl/irfb_queue.sv]
// Small flop-based queue of built frames between the front end and the serializer.
// Depends on irfb_pkg.
module irfb_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  irfb_pkg::frame_body_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output irfb_pkg::frame_body_t pop_data
);
    import irfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_body_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_FULL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/irfb_back.sv]
// Back end: serializes a queued frame as 18 words, accumulating the CRC-8 as it goes.
// Depends on irfb_pkg.
module irfb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  irfb_pkg::frame_body_t pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output irfb_pkg::frame_word_t out_data
);
    import irfb_pkg::*;

    logic [WORD_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]            crc_reg, crc_next;
    logic                  out_valid_reg, out_valid_next;
    frame_word_t           out_data_reg, out_data_next;
    logic                  issue;
    logic                  is_last;
    logic [WORD_IDX_W-1:0] body_idx;
    logic [31:0]           body_word;
    logic [7:0]            crc_base;
    logic [7:0]            crc_final;

    // A word is issued whenever a frame is queued and the output register frees up.
    assign issue     = pop_valid && (!out_valid_reg || out_ready);
    assign is_last   = (idx_reg == LAST_WORD_IDX);
    assign pop_ready = issue && is_last;
    assign body_idx  = is_last ? FIRST_WORD_IDX : idx_reg;
    assign body_word = pop_data.words[body_idx];
    assign crc_base  = (idx_reg == FIRST_WORD_IDX) ? CRC_INIT : crc_reg;
    assign crc_final = crc8_byte(crc_reg, pop_data.status_byte);

    // Word select, CRC update and output register load.
    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (issue)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                idx_next                = FIRST_WORD_IDX;
                out_data_next.out_word  = {FOOTER_LF, FOOTER_CR, crc_final,
                                           pop_data.status_byte};
                out_data_next.last_word = 1'b1;
            end
            else
            begin
                idx_next                = idx_reg + WORD_IDX_W'(1);
                crc_next                = crc8_word(crc_base, body_word);
                out_data_next.out_word  = body_word;
                out_data_next.last_word = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= FIRST_WORD_IDX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/imu_record_frame_builder.sv]
// Channel  Handshake             Payload                 Per record
// in       in_valid / in_ready   irfb_pkg::imu_record_t  one beat
// out      out_valid / out_ready irfb_pkg::frame_word_t  18 beats, last_word on the final one
//
// Each record becomes one 72-byte frame sent as 18 beats, one per cycle while out_ready is
// high; the output word serializer, not the record intake, sets the sustained record rate.
// Records are accepted back to back until QUEUE_DEPTH built frames wait for the serializer.
// An accepted record is stored in the queue; its first output beat is then loaded into the output register.
// rst_n clears the frame counter, queue and output valid; no clearing pass is needed.
// A stalled output holds its beat and lets the front keep filling the queue.
//
// Top level of the IMU record frame builder; depends on irfb_pkg, irfb_front,
// irfb_queue and irfb_back.
module imu_record_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  irfb_pkg::imu_record_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output irfb_pkg::frame_word_t out_data
);
    import irfb_pkg::*;

    logic        push_valid;
    logic        push_ready;
    frame_body_t push_data;
    logic        pop_valid;
    logic        pop_ready;
    frame_body_t pop_data;

    // Record intake and frame layout.
    irfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Built frames waiting for the serializer.
    irfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Word serializer with CRC.
    irfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/irfb_checker.sv]
// Port-level checks for the IMU record frame builder, bound to the top level.
// Depends on irfb_pkg and imu_record_frame_builder.
module irfb_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input irfb_pkg::imu_record_t in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input irfb_pkg::frame_word_t out_data
);
    import irfb_pkg::*;

    logic out_beat;

    assign out_beat = out_valid && out_ready;

    // A waiting record beat stays presented and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while waiting");

    // A stalled output beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // The final beat of a frame carries the footer.
    a_footer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_word |-> out_data.out_word[31:16] == {FOOTER_LF, FOOTER_CR})
        else $error("last beat lacks the frame footer");

    // Within a frame the serializer never leaves a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && !out_data.last_word |=> out_valid)
        else $error("gap inside a frame");

    // A beat that follows the end of a frame opens the next frame with its header.
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_beat && out_data.last_word) && out_valid |-> out_data.out_word == HDR_WORD)
        else $error("frame does not start with the header");

endmodule

bind imu_record_frame_builder irfb_checker u_checker (.*);
